// ----- hw/rtl/rsmws_pkg.sv -----
// ----------------------------------------------------------------------------
// rsmws_pkg
// Shared constants, types and codes for the RSSI spike clipper, median filter
// and window statistics block.
// ----------------------------------------------------------------------------
package rsmws_pkg;

  localparam int RING_DEPTH      = 32;
  localparam int RING_AW         = $clog2(RING_DEPTH);
  localparam int ANALYSIS_WINDOW = 30;
  localparam int FILL_W          = $clog2(ANALYSIS_WINDOW + 1);
  localparam int MEDIAN_TAPS     = 7;
  localparam int MEDIAN_HALF     = 3;
  localparam int RANK_W          = $clog2(MEDIAN_TAPS);
  localparam int STEP_W          = $clog2(ANALYSIS_WINDOW + MEDIAN_HALF + 1);

  localparam int SUM_W   = 13;
  localparam int SUMSQ_W = 19;
  localparam int PROD_W  = 24;

  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_Q_W   = 22;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W);

  localparam logic signed [7:0] UNINIT_MARK = -8'sd127;

  localparam logic [7:0] SPIKE_THRESHOLD_RST  = 8'd15;
  localparam logic [7:0] SPIKE_PERSIST_RST    = 8'd5;
  localparam logic [9:0] SAMPLE_PERIOD_MS_RST = 10'd20;

  typedef enum logic [1:0] {
    CFG_SPIKE_THRESHOLD  = 2'd0,
    CFG_SPIKE_PERSIST    = 2'd1,
    CFG_SAMPLE_PERIOD_MS = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STREAM,
    S_DRAIN,
    S_MUL,
    S_DIVM,
    S_DIVV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] q;
  } div_rsp_t;

endpackage

// ----- hw/rtl/rssi_spike_median_window_stats_top.sv -----
// ----------------------------------------------------------------------------
// rssi_spike_median_window_stats_top
// While fewer than seven samples are held, the result is formed straight from
// the accepted sample; otherwise n + 3 ring reads (n = samples in the window,
// 7 to 30) feed the median pipeline, and two divisions then give the mean and
// variance. A new sample is taken only in the idle state, after the result is
// loaded, so a stalled result register also holds off the next sample.
// Reset is synchronous and active low and restores the register defaults.
// ----------------------------------------------------------------------------
module rssi_spike_median_window_stats_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [9:0]              cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [7:0]       in_rssi_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [7:0]       out_current_rssi,
  output logic signed [7:0]       out_filtered_rssi,
  output logic signed [7:0]       out_min_rssi,
  output logic signed [7:0]       out_max_rssi,
  output logic signed [15:0]      out_mean_q8,
  output logic [21:0]             out_variance_q8,
  output logic [4:0]              out_median_count,
  output logic [14:0]             out_window_ms,
  output logic                    out_stats_valid
);

  localparam int AW = rsmws_pkg::RING_AW;
  localparam int SW = rsmws_pkg::STEP_W;
  localparam int FW = rsmws_pkg::FILL_W;

  rsmws_pkg::state_t state_r, state_nxt;

  logic [7:0]  thr_r, persist_r;
  logic [9:0]  period_r;

  logic [AW-1:0]     wr_idx_r, base_r;
  logic [FW-1:0]     fill_r, fill_nxt, n_r;
  logic signed [7:0] last_acc_r, run_dummy;
  logic [7:0]        run_r;

  logic [SW-1:0] t_r, tag_d1_r, tag_d2_r, tag_d3_r, off;
  logic          v_d1_r, v_d2_r, v_d3_r;
  logic [AW:0]   addr_ext;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic signed [7:0] med;

  logic signed [rsmws_pkg::SUM_W-1:0] sum_r;
  logic [rsmws_pkg::SUM_W-1:0]        sum_abs;
  logic [rsmws_pkg::SUMSQ_W-1:0]      sumsq_r;
  logic signed [7:0]                  min_r, max_r;
  logic [rsmws_pkg::PROD_W-1:0]       prod_a_r, prod_b_r;
  logic [9:0]                         csq_r;
  logic [4:0]                         cnt;
  logic                               stats_r;

  logic signed [7:0]  res_cur_r, res_filt_r;
  logic signed [15:0] res_mean_r;
  logic [21:0]        res_var_r;
  logic [14:0]        res_wms_r;

  logic              accept, short_win, load;
  logic signed [7:0] la, clip_cur, clip_la;
  logic [7:0]        clip_run, run_inc;
  logic signed [8:0] diff;
  logic [7:0]        diff_abs;
  logic [15:0]       mean_mag;

  rsmws_pkg::div_req_t div_req;
  rsmws_pkg::div_rsp_t div_rsp;

  assign run_dummy = '0;
  assign in_ready  = (state_r == rsmws_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign fill_nxt  = (fill_r == FW'(rsmws_pkg::ANALYSIS_WINDOW)) ? fill_r : fill_r + 1'b1;
  assign short_win = fill_nxt < FW'(rsmws_pkg::MEDIAN_TAPS);
  assign cnt       = 5'(n_r - FW'(rsmws_pkg::MEDIAN_TAPS - 1));
  assign sum_abs   = sum_r[rsmws_pkg::SUM_W-1] ? rsmws_pkg::SUM_W'(-sum_r) : sum_r;
  assign load      = (state_r == rsmws_pkg::S_DONE) && (!out_valid || out_ready);
  assign mean_mag  = div_rsp.q[15:0];

  // Spike clipper.
  always_comb begin
    la       = (last_acc_r == rsmws_pkg::UNINIT_MARK) ? in_rssi_sample : last_acc_r;
    diff     = 9'(in_rssi_sample) - 9'(la);
    diff_abs = diff[8] ? 8'(-diff) : diff[7:0];
    run_inc  = run_r + 1'b1;
    clip_cur = in_rssi_sample;
    clip_la  = in_rssi_sample;
    clip_run = '0;
    if (diff_abs > thr_r) begin
      if (run_inc <= persist_r) begin
        clip_cur = la;
        clip_la  = la;
        clip_run = run_inc;
      end
    end
  end

  // Ring read address for the current stream step.
  always_comb begin
    off      = (t_r < SW'(rsmws_pkg::MEDIAN_HALF)) ? '0 : t_r - SW'(rsmws_pkg::MEDIAN_HALF);
    if ({1'b0, base_r} >= (AW+1)'(off)) begin
      addr_ext = {1'b0, base_r} - (AW+1)'(off);
    end else begin
      addr_ext = {1'b0, base_r} + (AW+1)'(rsmws_pkg::RING_DEPTH) - (AW+1)'(off);
    end
    raddr = addr_ext[AW-1:0];
  end

  rsmws_ram #(
    .WIDTH(8),
    .DEPTH(rsmws_pkg::RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(wr_idx_r),
    .wdata(in_rssi_sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  rsmws_median u_median (
    .clk  (clk),
    .push (v_d1_r),
    .din  ($signed(rdata)),
    .med_r(med)
  );

  rsmws_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = rsmws_pkg::DIV_NUM_W'(sum_abs) << 8;
    div_req.den   = rsmws_pkg::DIV_DEN_W'(cnt);
    if (state_r == rsmws_pkg::S_MUL) begin
      div_req.start = 1'b1;
    end else if ((state_r == rsmws_pkg::S_DIVM) && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.num   = rsmws_pkg::DIV_NUM_W'(prod_a_r - prod_b_r) << 8;
      div_req.den   = csq_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsmws_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = short_win ? rsmws_pkg::S_DONE : rsmws_pkg::S_STREAM;
        end
      end
      rsmws_pkg::S_STREAM: begin
        if (t_r == SW'(n_r) + SW'(rsmws_pkg::MEDIAN_HALF - 1)) begin
          state_nxt = rsmws_pkg::S_DRAIN;
        end
      end
      rsmws_pkg::S_DRAIN: begin
        if (!v_d1_r && !v_d2_r && !v_d3_r) begin
          state_nxt = rsmws_pkg::S_MUL;
        end
      end
      rsmws_pkg::S_MUL: begin
        state_nxt = rsmws_pkg::S_DIVM;
      end
      rsmws_pkg::S_DIVM: begin
        if (div_rsp.done) begin
          state_nxt = rsmws_pkg::S_DIVV;
        end
      end
      rsmws_pkg::S_DIVV: begin
        if (div_rsp.done) begin
          state_nxt = rsmws_pkg::S_DONE;
        end
      end
      rsmws_pkg::S_DONE: begin
        if (load) begin
          state_nxt = rsmws_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rsmws_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsmws_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= rsmws_pkg::SPIKE_THRESHOLD_RST;
      persist_r  <= rsmws_pkg::SPIKE_PERSIST_RST;
      period_r   <= rsmws_pkg::SAMPLE_PERIOD_MS_RST;
      wr_idx_r   <= '0;
      fill_r     <= '0;
      last_acc_r <= rsmws_pkg::UNINIT_MARK;
      run_r      <= '0;
      v_d1_r     <= 1'b0;
      v_d2_r     <= 1'b0;
      v_d3_r     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rsmws_pkg::CFG_SPIKE_THRESHOLD:  thr_r    <= cfg_wdata[7:0];
          rsmws_pkg::CFG_SPIKE_PERSIST:    persist_r <= cfg_wdata[7:0];
          rsmws_pkg::CFG_SAMPLE_PERIOD_MS: period_r <= cfg_wdata;
          default: begin
            thr_r <= thr_r;
          end
        endcase
      end
      if (accept) begin
        wr_idx_r <= (wr_idx_r == AW'(rsmws_pkg::RING_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
        fill_r   <= fill_nxt;
        if (!short_win) begin
          last_acc_r <= clip_la;
          run_r      <= clip_run | run_dummy;
        end
      end
      v_d1_r <= (state_r == rsmws_pkg::S_STREAM);
      v_d2_r <= v_d1_r;
      v_d3_r <= v_d2_r;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    tag_d1_r <= t_r;
    tag_d2_r <= tag_d1_r;
    tag_d3_r <= tag_d2_r;
    if (accept) begin
      base_r     <= wr_idx_r;
      n_r        <= fill_nxt;
      t_r        <= '0;
      stats_r    <= !short_win;
      res_cur_r  <= short_win ? in_rssi_sample : clip_cur;
      res_filt_r <= in_rssi_sample;
      res_mean_r <= '0;
      res_var_r  <= '0;
      res_wms_r  <= '0;
      sum_r      <= '0;
      sumsq_r    <= '0;
      min_r      <= 8'sd127;
      max_r      <= -8'sd128;
    end
    if (state_r == rsmws_pkg::S_STREAM) begin
      t_r <= t_r + 1'b1;
    end
    if (v_d3_r && (tag_d3_r == SW'(rsmws_pkg::MEDIAN_TAPS - 1))) begin
      res_filt_r <= med;
    end
    if (v_d3_r && (tag_d3_r >= SW'(rsmws_pkg::MEDIAN_TAPS - 1 + rsmws_pkg::MEDIAN_HALF))) begin
      sum_r   <= sum_r + rsmws_pkg::SUM_W'(med);
      sumsq_r <= sumsq_r + rsmws_pkg::SUMSQ_W'(unsigned'(16'(med * med)));
      if (med < min_r) begin
        min_r <= med;
      end
      if (med > max_r) begin
        max_r <= med;
      end
    end
    if (state_r == rsmws_pkg::S_MUL) begin
      prod_a_r  <= rsmws_pkg::PROD_W'(cnt * sumsq_r);
      prod_b_r  <= rsmws_pkg::PROD_W'(sum_abs * sum_abs);
      csq_r     <= 10'(cnt * cnt);
      res_wms_r <= 15'(cnt * period_r);
    end
    if ((state_r == rsmws_pkg::S_DIVM) && div_rsp.done) begin
      res_mean_r <= sum_r[rsmws_pkg::SUM_W-1] ? 16'(-mean_mag) : mean_mag;
    end
    if ((state_r == rsmws_pkg::S_DIVV) && div_rsp.done) begin
      res_var_r <= div_rsp.q;
    end
    if (load) begin
      out_current_rssi  <= res_cur_r;
      out_filtered_rssi <= res_filt_r;
      out_min_rssi      <= stats_r ? min_r : '0;
      out_max_rssi      <= stats_r ? max_r : '0;
      out_mean_q8       <= res_mean_r;
      out_variance_q8   <= res_var_r;
      out_median_count  <= stats_r ? cnt : '0;
      out_window_ms     <= res_wms_r;
      out_stats_valid   <= stats_r;
    end
  end

endmodule

// ----- hw/rtl/rsmws_ram.sv -----
// ----------------------------------------------------------------------------
// rsmws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rsmws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rsmws_median.sv -----
// ----------------------------------------------------------------------------
// rsmws_median
// Seven-tap sample window fed one word at a time, with a registered
// rank-select median of the current window.
// ----------------------------------------------------------------------------
module rsmws_median (
  input  logic              clk,
  input  logic              push,
  input  logic signed [7:0] din,
  output logic signed [7:0] med_r
);

  logic signed [7:0]                 win_r [rsmws_pkg::MEDIAN_TAPS];
  logic        [rsmws_pkg::RANK_W-1:0] rank  [rsmws_pkg::MEDIAN_TAPS];
  logic signed [7:0]                 med_nxt;

  always_comb begin
    for (int j = 0; j < rsmws_pkg::MEDIAN_TAPS; j++) begin
      rank[j] = '0;
      for (int k = 0; k < rsmws_pkg::MEDIAN_TAPS; k++) begin
        if (k != j) begin
          if ((win_r[k] < win_r[j]) || ((win_r[k] == win_r[j]) && (k < j))) begin
            rank[j] = rank[j] + 1'b1;
          end
        end
      end
    end
    med_nxt = win_r[0];
    for (int j = 0; j < rsmws_pkg::MEDIAN_TAPS; j++) begin
      if (rank[j] == rsmws_pkg::RANK_W'(rsmws_pkg::MEDIAN_HALF)) begin
        med_nxt = win_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      win_r[0] <= din;
      for (int j = 1; j < rsmws_pkg::MEDIAN_TAPS; j++) begin
        win_r[j] <= win_r[j-1];
      end
    end
    med_r <= med_nxt;
  end

endmodule

// ----- hw/rtl/rsmws_div.sv -----
// ----------------------------------------------------------------------------
// rsmws_div
// Shared restoring divider giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsmws_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rsmws_pkg::div_req_t req,
  output rsmws_pkg::div_rsp_t rsp
);

  logic [rsmws_pkg::DIV_NUM_W-1:0] rem_r;
  logic [rsmws_pkg::DIV_NUM_W-1:0] dsh_r;
  logic [rsmws_pkg::DIV_Q_W-1:0]   q_r;
  logic [rsmws_pkg::DIV_CNT_W-1:0] i_r;
  logic                            busy_r;
  logic                            done_r;
  logic                            ge;

  assign ge       = rem_r >= dsh_r;
  assign rsp.done = done_r;
  assign rsp.q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (i_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsh_r <= rsmws_pkg::DIV_NUM_W'(req.den) << (rsmws_pkg::DIV_Q_W - 1);
      q_r   <= '0;
      i_r   <= rsmws_pkg::DIV_CNT_W'(rsmws_pkg::DIV_Q_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[rsmws_pkg::DIV_Q_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
      i_r   <= i_r - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/rsmws_checker.sv -----
// ----------------------------------------------------------------------------
// rsmws_props
// Port-level checks on the statistics block, bound to its top level.
// ----------------------------------------------------------------------------
module rsmws_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [7:0]  out_current_rssi,
  input logic signed [7:0]  out_min_rssi,
  input logic signed [7:0]  out_max_rssi,
  input logic signed [15:0] out_mean_q8,
  input logic [4:0]         out_median_count,
  input logic [14:0]        out_window_ms,
  input logic               out_stats_valid
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_current_rssi)))
    else $error("stalled result changed");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stats_valid) |->
      (out_min_rssi == 0 && out_max_rssi == 0 && out_mean_q8 == 0 &&
       out_median_count == 0 && out_window_ms == 0))
    else $error("short window result carries statistics");

  a_stats_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stats_valid) |->
      (out_median_count != 0 && out_median_count <= 5'd24 &&
       out_min_rssi <= out_max_rssi))
    else $error("statistics out of range");

endmodule

bind rssi_spike_median_window_stats_top rsmws_props u_rsmws_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_current_rssi (out_current_rssi),
  .out_min_rssi     (out_min_rssi),
  .out_max_rssi     (out_max_rssi),
  .out_mean_q8      (out_mean_q8),
  .out_median_count (out_median_count),
  .out_window_ms    (out_window_ms),
  .out_stats_valid  (out_stats_valid)
);
